>>> src/sbe_pkg.sv
`default_nettype none

package sbe_pkg;

    // Screen geometry of the target framebuffer.
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    // Field widths of the item interfaces.
    localparam int COORD_W      = 11;
    localparam int SIZE_W       = 8;
    localparam int COLOR_W      = 16;
    localparam int FRAME_ADDR_W = 17;

    // Internal widths; X_W, Y_W and XY_W derive from the screen size.
    localparam int ORIGIN_W = 12;
    localparam int X_W      = $clog2(SCREEN_WIDTH);
    localparam int Y_W      = $clog2(SCREEN_HEIGHT);
    localparam int XY_W     = X_W + Y_W;
    localparam int CALC_W   = (XY_W > FRAME_ADDR_W) ? XY_W : FRAME_ADDR_W;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } t_command;

    // One framebuffer write on its way from the raster stage to the address stage.
    typedef struct packed {
        logic [X_W-1:0]     col;
        logic [Y_W-1:0]     row;
        logic [COLOR_W-1:0] color;
    } t_hit;

endpackage

`default_nettype wire

>>> src/sprite_blit_engine_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  command, origin, size, mode flags, color, opaque
// result    out        o_valid / i_stall  frame_address, write_color
//
// One item is accepted per clock while o_stall is low; a pixel that makes a
// write passes the raster register, then the address register, to the result.
// The path from the raster register to the result register holds the one
// row-times-width multiplier, which sets the clock budget of the block.
// Reset is synchronous on i_rst_n and clears the draw state and both valids.
// The input stalls only when both the raster register and the result
// register hold writes and the result side is stalling.
`default_nettype none

module sprite_blit_engine_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_command,
    input  wire logic [sbe_pkg::COORD_W-1:0]      i_dest_x,
    input  wire logic [sbe_pkg::COORD_W-1:0]      i_dest_y,
    input  wire logic [sbe_pkg::SIZE_W-1:0]       i_sprite_width,
    input  wire logic [sbe_pkg::SIZE_W-1:0]       i_sprite_height,
    input  wire logic                             i_mirror_x,
    input  wire logic                             i_anchor_bottom,
    input  wire logic                             i_center_horizontal,
    input  wire logic                             i_center_vertical,
    input  wire logic [sbe_pkg::COLOR_W-1:0]      i_pixel_color,
    input  wire logic                             i_pixel_opaque,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [sbe_pkg::FRAME_ADDR_W-1:0]      o_frame_address,
    output logic [sbe_pkg::COLOR_W-1:0]           o_write_color
);
    import sbe_pkg::*;

    logic s1_valid;
    t_hit s1;
    logic advance;
    logic take;
    logic accept;

    // The raster register can load whenever it is empty or moving on, so a
    // waiting result blocks the input only while the raster register holds a write.
    assign take    = !s1_valid || advance;
    assign o_stall = !take;
    assign accept  = i_valid && take;

    // Draw state, raster position, mirroring, anchoring and screen clipping.
    sbe_raster u_raster (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_take              (take),
        .i_command           (i_command),
        .i_dest_x            (i_dest_x),
        .i_dest_y            (i_dest_y),
        .i_sprite_width      (i_sprite_width),
        .i_sprite_height     (i_sprite_height),
        .i_mirror_x          (i_mirror_x),
        .i_anchor_bottom     (i_anchor_bottom),
        .i_center_horizontal (i_center_horizontal),
        .i_center_vertical   (i_center_vertical),
        .i_pixel_color       (i_pixel_color),
        .i_pixel_opaque      (i_pixel_opaque),
        .o_s1_valid          (s1_valid),
        .o_s1                (s1)
    );

    // Framebuffer address and the result register.
    sbe_addr u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (s1_valid),
        .i_s1            (s1),
        .i_stall         (i_stall),
        .o_advance       (advance),
        .o_valid         (o_valid),
        .o_frame_address (o_frame_address),
        .o_write_color   (o_write_color)
    );

endmodule

`default_nettype wire

>>> src/sbe_raster.sv
`default_nettype none

module sbe_raster (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_take,
    input  wire logic                         i_command,
    input  wire logic [sbe_pkg::COORD_W-1:0]  i_dest_x,
    input  wire logic [sbe_pkg::COORD_W-1:0]  i_dest_y,
    input  wire logic [sbe_pkg::SIZE_W-1:0]   i_sprite_width,
    input  wire logic [sbe_pkg::SIZE_W-1:0]   i_sprite_height,
    input  wire logic                         i_mirror_x,
    input  wire logic                         i_anchor_bottom,
    input  wire logic                         i_center_horizontal,
    input  wire logic                         i_center_vertical,
    input  wire logic [sbe_pkg::COLOR_W-1:0]  i_pixel_color,
    input  wire logic                         i_pixel_opaque,
    output logic                              o_s1_valid,
    output sbe_pkg::t_hit                     o_s1
);
    import sbe_pkg::*;

    logic                       r_active;
    logic signed [ORIGIN_W-1:0] r_origin_x;
    logic signed [ORIGIN_W-1:0] r_origin_y;
    logic [SIZE_W-1:0]          r_width;
    logic [SIZE_W-1:0]          r_height;
    logic                       r_mirror;
    logic [SIZE_W-1:0]          r_col;
    logic [SIZE_W-1:0]          r_row;
    logic                       r_s1_valid;
    t_hit                       r_s1;

    logic                       start;
    logic                       pixel;
    logic signed [ORIGIN_W-1:0] dest_x_ext;
    logic signed [ORIGIN_W-1:0] dest_y_ext;
    logic [ORIGIN_W-1:0]        x_shift;
    logic [ORIGIN_W-1:0]        y_shift;
    logic [SIZE_W-1:0]          dx;
    logic signed [ORIGIN_W-1:0] sx;
    logic signed [ORIGIN_W-1:0] sy;
    logic                       in_x;
    logic                       in_y;
    logic                       col_last;
    logic                       row_last;
    logic                       n_hit_valid;
    t_hit                       n_hit;

    assign start = i_accept && (i_command == CMD_START);
    assign pixel = i_accept && (i_command == CMD_PIXEL) && r_active;

    // Anchor shifts; vertical centering wins over bottom anchoring.
    assign dest_x_ext = {i_dest_x[COORD_W-1], i_dest_x};
    assign dest_y_ext = {i_dest_y[COORD_W-1], i_dest_y};
    assign x_shift = i_center_horizontal ?
                     ORIGIN_W'(i_sprite_width[SIZE_W-1:1]) : '0;
    always_comb begin
        if (i_center_vertical) begin
            y_shift = ORIGIN_W'(i_sprite_height[SIZE_W-1:1]);
        end else if (i_anchor_bottom) begin
            y_shift = ORIGIN_W'(i_sprite_height);
        end else begin
            y_shift = '0;
        end
    end

    // Screen position of the current source pixel.
    assign dx = r_mirror ? (r_width - SIZE_W'(1) - r_col) : r_col;
    assign sx = r_origin_x + $signed(ORIGIN_W'(dx));
    assign sy = r_origin_y + $signed(ORIGIN_W'(r_row));
    assign in_x = !sx[ORIGIN_W-1] && (sx < $signed(ORIGIN_W'(SCREEN_WIDTH)));
    assign in_y = !sy[ORIGIN_W-1] && (sy < $signed(ORIGIN_W'(SCREEN_HEIGHT)));

    assign col_last = ({1'b0, r_col} + 9'd1) >= {1'b0, r_width};
    assign row_last = ({1'b0, r_row} + 9'd1) >= {1'b0, r_height};

    assign n_hit_valid = pixel && i_pixel_opaque && in_x && in_y;
    assign n_hit.col   = sx[X_W-1:0];
    assign n_hit.row   = sy[Y_W-1:0];
    assign n_hit.color = i_pixel_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_mirror   <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (start) begin
            r_origin_x <= dest_x_ext - $signed(x_shift);
            r_origin_y <= dest_y_ext - $signed(y_shift);
            r_width    <= i_sprite_width;
            r_height   <= i_sprite_height;
            r_mirror   <= i_mirror_x;
            r_col      <= '0;
            r_row      <= '0;
            r_active   <= (i_sprite_width != '0) && (i_sprite_height != '0);
        end else if (pixel) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row    <= '0;
                    r_active <= 1'b0;
                end else begin
                    r_row <= r_row + SIZE_W'(1);
                end
            end else begin
                r_col <= r_col + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_take) begin
            r_s1_valid <= n_hit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= n_hit;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

>>> src/sbe_addr.sv
`default_nettype none

module sbe_addr (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s1_valid,
    input  wire sbe_pkg::t_hit                    i_s1,
    input  wire logic                             i_stall,
    output logic                                  o_advance,
    output logic                                  o_valid,
    output logic [sbe_pkg::FRAME_ADDR_W-1:0]      o_frame_address,
    output logic [sbe_pkg::COLOR_W-1:0]           o_write_color
);
    import sbe_pkg::*;

    logic                    r_valid;
    logic [FRAME_ADDR_W-1:0] r_addr;
    logic [COLOR_W-1:0]      r_color;
    logic [CALC_W-1:0]       addr_full;

    // Row times screen width plus column, kept to the address field width.
    assign addr_full = CALC_W'(i_s1.row) * CALC_W'(SCREEN_WIDTH) + CALC_W'(i_s1.col);

    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_s1_valid) begin
            r_addr  <= addr_full[FRAME_ADDR_W-1:0];
            r_color <= i_s1.color;
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_address = r_addr;
    assign o_write_color   = r_color;

endmodule

`default_nettype wire

>>> src/sbe_checker.sv
`default_nettype none

module sbe_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_stall,
    input wire logic                             o_valid,
    input wire logic                             i_stall,
    input wire logic [sbe_pkg::FRAME_ADDR_W-1:0] o_frame_address,
    input wire logic [sbe_pkg::COLOR_W-1:0]      o_write_color
);
    import sbe_pkg::*;

    // A stalled write stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("write dropped while stalled");

    // A stalled write keeps its address and color.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_frame_address) && $stable(o_write_color))
        else $error("write payload changed while stalled");

    // The input only stalls when a write is waiting on a stalled output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back pressure");

    // Every address lies inside the framebuffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_frame_address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)))
        else $error("frame address beyond the screen");

    // Reset leaves no write pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("write pending after reset");

endmodule

bind sprite_blit_engine_unit sbe_checker u_sbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_address (o_frame_address),
    .o_write_color   (o_write_color)
);

`default_nettype wire

>>> tb/tb_sprite_blit_engine_unit.sv
`timescale 1ns / 1ps

module tb_sprite_blit_engine_unit;
    import sbe_pkg::*;

    // A cycle budget with no item moving on either channel. The slowest
    // legitimate wait is the long receiver hold-off, so this leaves a wide margin.
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 310;

    // One input item, with every field present whatever the command.
    typedef struct {
        t_command                   command;
        logic signed [COORD_W-1:0]  dest_x;
        logic signed [COORD_W-1:0]  dest_y;
        logic [SIZE_W-1:0]          sprite_width;
        logic [SIZE_W-1:0]          sprite_height;
        logic                       mirror_x;
        logic                       anchor_bottom;
        logic                       center_horizontal;
        logic                       center_vertical;
        logic [COLOR_W-1:0]         pixel_color;
        logic                       pixel_opaque;
    } t_blit_item;

    // One framebuffer write as the block should emit it.
    typedef struct {
        logic [FRAME_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]      color;
    } t_frame_write;

    // The scoreboard keeps its own copy of the draw state. Every accepted
    // item advances it, and every pixel that lands opaque on the screen
    // queues the write that must come out of the block next in order.
    class blit_scoreboard;
        bit           active;
        int           org_x;
        int           org_y;
        int unsigned  wid;
        int unsigned  hgt;
        bit           mirror;
        int unsigned  col;
        int unsigned  row;
        t_frame_write pending_writes[$];
        int unsigned  mismatches;
        int unsigned  writes_checked;

        function void note_item(input t_blit_item it);
            int           shift_x;
            int           shift_y;
            int           col_pos;
            int           row_pos;
            int unsigned  dx;
            t_frame_write wr;
            if (it.command == CMD_START) begin
                shift_x = 0;
                shift_y = 0;
                if (it.anchor_bottom) shift_y = -int'(it.sprite_height);
                if (it.center_horizontal) shift_x = -int'(it.sprite_width / 2);
                // Vertical centering wins over the bottom anchor.
                if (it.center_vertical) shift_y = -int'(it.sprite_height / 2);
                org_x  = int'(it.dest_x) + shift_x;
                org_y  = int'(it.dest_y) + shift_y;
                wid    = it.sprite_width;
                hgt    = it.sprite_height;
                mirror = it.mirror_x;
                col    = 0;
                row    = 0;
                active = (wid != 0) && (hgt != 0);
            end else if (active) begin
                dx      = mirror ? (wid - 1 - col) : col;
                col_pos = org_x + int'(dx);
                row_pos = org_y + int'(row);
                if (it.pixel_opaque && col_pos >= 0 && col_pos < SCREEN_WIDTH &&
                    row_pos >= 0 && row_pos < SCREEN_HEIGHT) begin
                    wr.addr  = FRAME_ADDR_W'(row_pos * SCREEN_WIDTH + col_pos);
                    wr.color = it.pixel_color;
                    pending_writes.push_back(wr);
                end
                if (col + 1 >= wid) begin
                    col = 0;
                    row++;
                    if (row >= hgt) begin
                        row    = 0;
                        active = 0;
                    end
                end else begin
                    col++;
                end
            end
        endfunction

        function void check_write(input logic [FRAME_ADDR_W-1:0] addr,
                                  input logic [COLOR_W-1:0] color);
            t_frame_write wr;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write, address %0d color %h", $time, addr, color);
                mismatches++;
            end else begin
                wr = pending_writes.pop_front();
                writes_checked++;
                if (addr !== wr.addr) begin
                    $display("%0t: frame_address expected %0d actual %0d",
                             $time, wr.addr, addr);
                    mismatches++;
                end
                if (color !== wr.color) begin
                    $display("%0t: write_color expected %h actual %h",
                             $time, wr.color, color);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_command;
    logic [COORD_W-1:0]      i_dest_x;
    logic [COORD_W-1:0]      i_dest_y;
    logic [SIZE_W-1:0]       i_sprite_width;
    logic [SIZE_W-1:0]       i_sprite_height;
    logic                    i_mirror_x;
    logic                    i_anchor_bottom;
    logic                    i_center_horizontal;
    logic                    i_center_vertical;
    logic [COLOR_W-1:0]      i_pixel_color;
    logic                    i_pixel_opaque;
    logic                    o_valid;
    logic                    i_stall;
    logic [FRAME_ADDR_W-1:0] o_frame_address;
    logic [COLOR_W-1:0]      o_write_color;

    blit_scoreboard blit_board;

    // Idle rates, in percent, for the two sides. The main sequence changes
    // them between phases while nothing is in flight.
    int send_idle_pct;
    int recv_idle_pct;

    // The sender raises this to ask the receiver for one long hold-off.
    bit hold_request;

    int unsigned useful_items;
    int unsigned input_stall_cycles;
    int unsigned holds_done;
    int unsigned idle_run;

    sprite_blit_engine_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_dest_x            (i_dest_x),
        .i_dest_y            (i_dest_y),
        .i_sprite_width      (i_sprite_width),
        .i_sprite_height     (i_sprite_height),
        .i_mirror_x          (i_mirror_x),
        .i_anchor_bottom     (i_anchor_bottom),
        .i_center_horizontal (i_center_horizontal),
        .i_center_vertical   (i_center_vertical),
        .i_pixel_color       (i_pixel_color),
        .i_pixel_opaque      (i_pixel_opaque),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_frame_address     (o_frame_address),
        .o_write_color       (o_write_color)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Every field gets a random value, so the fields that the command does
    // not use are exercised as noise the block must ignore.
    function automatic t_blit_item random_fields();
        t_blit_item it;
        it.command           = t_command'(1'($urandom_range(1)));
        it.dest_x            = COORD_W'($urandom_range(2047));
        it.dest_y            = COORD_W'($urandom_range(2047));
        it.sprite_width      = SIZE_W'($urandom_range(255));
        it.sprite_height     = SIZE_W'($urandom_range(255));
        it.mirror_x          = 1'($urandom_range(1));
        it.anchor_bottom     = 1'($urandom_range(1));
        it.center_horizontal = 1'($urandom_range(1));
        it.center_vertical   = 1'($urandom_range(1));
        it.pixel_color       = COLOR_W'($urandom_range(65535));
        it.pixel_opaque      = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_blit_item start_item(input int x, input int y,
                                              input int unsigned w, input int unsigned h,
                                              input bit mir, input bit bot,
                                              input bit ctr_h, input bit ctr_v);
        t_blit_item it;
        it                   = random_fields();
        it.command           = CMD_START;
        it.dest_x            = COORD_W'(x);
        it.dest_y            = COORD_W'(y);
        it.sprite_width      = SIZE_W'(w);
        it.sprite_height     = SIZE_W'(h);
        it.mirror_x          = mir;
        it.anchor_bottom     = bot;
        it.center_horizontal = ctr_h;
        it.center_vertical   = ctr_v;
        return it;
    endfunction

    function automatic t_blit_item pixel_item(input logic [COLOR_W-1:0] color,
                                              input bit opaque);
        t_blit_item it;
        it              = random_fields();
        it.command      = CMD_PIXEL;
        it.pixel_color  = color;
        it.pixel_opaque = opaque;
        return it;
    endfunction

    // Offers one item at a falling edge and holds it until a rising edge
    // finds the block not stalling. Valid stays high afterwards, so back to
    // back items keep it high; only an idle gap or a drain lowers it.
    task automatic send_item(input t_blit_item it);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid             <= 1'b1;
        i_command           <= it.command;
        i_dest_x            <= it.dest_x;
        i_dest_y            <= it.dest_y;
        i_sprite_width      <= it.sprite_width;
        i_sprite_height     <= it.sprite_height;
        i_mirror_x          <= it.mirror_x;
        i_anchor_bottom     <= it.anchor_bottom;
        i_center_horizontal <= it.center_horizontal;
        i_center_vertical   <= it.center_vertical;
        i_pixel_color       <= it.pixel_color;
        i_pixel_opaque      <= it.pixel_opaque;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // Pixels that arrive with no draw running are not counted as work.
        if (it.command == CMD_START || blit_board.active) useful_items++;
        blit_board.note_item(it);
    endtask

    // The sender stops offering and waits until every queued write has
    // come out.
    task automatic drain_writes();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (blit_board.pending_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Short directed sequence: fields at their extremes, the top-left and
    // bottom-right screen corners, the anchor flags, and the draw-state corner cases.
    task automatic directed_items();
        // A pixel straight after reset has no draw to belong to.
        send_item(pixel_item(16'h1234, 1'b1));

        // A plain 3x2 sprite at the top-left corner, with one transparent
        // pixel, then one pixel past the end that must be ignored.
        send_item(start_item(0, 0, 3, 2, 0, 0, 0, 0));
        send_item(pixel_item(16'hFFFF, 1'b1));
        send_item(pixel_item(16'h0000, 1'b1));
        send_item(pixel_item(16'hABCD, 1'b0));
        send_item(pixel_item(16'h0001, 1'b1));
        send_item(pixel_item(16'h8000, 1'b1));
        send_item(pixel_item(16'h7FFF, 1'b1));
        send_item(pixel_item(16'h5555, 1'b1));

        // Mirrored row ending at the last framebuffer address.
        send_item(start_item(237, 319, 3, 1, 1, 0, 0, 0));
        send_item(pixel_item(16'h1111, 1'b1));
        send_item(pixel_item(16'h2222, 1'b1));
        send_item(pixel_item(16'h3333, 1'b1));

        // All three anchor flags together; vertical centering must win over
        // the bottom anchor. The draw is cut short by the next start.
        send_item(start_item(2, 1, 5, 3, 0, 1, 1, 1));
        send_item(pixel_item(16'h4444, 1'b1));
        send_item(pixel_item(16'h6666, 1'b1));

        // Most negative origin with the largest size: entirely off screen.
        send_item(start_item(-1024, -1024, 255, 255, 1, 1, 0, 0));
        send_item(pixel_item(16'h7777, 1'b1));

        // Most positive x, and a row just below the screen.
        send_item(start_item(1023, 5, 1, 1, 0, 0, 0, 0));
        send_item(pixel_item(16'h8888, 1'b1));
        send_item(start_item(10, 320, 1, 1, 0, 0, 0, 0));
        send_item(pixel_item(16'h9999, 1'b1));

        // Straddling the left edge: the first pixel is clipped, the second lands.
        send_item(start_item(-1, 0, 2, 1, 0, 0, 0, 0));
        send_item(pixel_item(16'hAAAA, 1'b1));
        send_item(pixel_item(16'hBBBB, 1'b1));

        // A zero width and then a zero height leave no draw active.
        send_item(start_item(5, 5, 0, 4, 0, 0, 0, 0));
        send_item(pixel_item(16'hCCCC, 1'b1));
        send_item(start_item(5, 5, 4, 0, 0, 0, 0, 0));
        send_item(pixel_item(16'hDDDD, 1'b1));
    endtask

    // A fully opaque on-screen sprite sent while the receiver holds off, so
    // the output stage fills and the block has to stall its input.
    task automatic flood_with_hold();
        int k;
        send_item(start_item(20, 30, 16, 2, 0, 0, 0, 0));
        hold_request = 1'b1;
        for (k = 0; k < 32; k++) send_item(pixel_item(COLOR_W'($urandom_range(65535)), 1'b1));
    endtask

    // One random sprite. Most are small; one of up to 64 pixels is usually sent
    // whole, others are cut off after at most 40 pixels by the next start. Now
    // and then one or two random items follow; pixels are ignored once it has ended.
    task automatic random_sprite();
        t_blit_item  it;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned npix;
        int unsigned k;
        w = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(1, 255);
        h = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(1, 255);
        it = start_item(0, 0, w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        // Keep most origins near the screen so that writes are common.
        if ($urandom_range(99) < 80) begin
            it.dest_x = COORD_W'(int'($urandom_range(280)) - 20);
            it.dest_y = COORD_W'(int'($urandom_range(360)) - 20);
        end
        send_item(it);
        area = w * h;
        if (area <= 64 && $urandom_range(99) < 90) begin
            npix = area;
        end else begin
            npix = $urandom_range(1, (area < 40) ? area : 40);
        end
        for (k = 0; k < npix; k++) begin
            send_item(pixel_item(COLOR_W'($urandom_range(65535)), $urandom_range(99) < 80));
        end
        if ($urandom_range(99) < 8) begin
            npix = $urandom_range(1, 2);
            for (k = 0; k < npix; k++) send_item(random_fields());
        end
    endtask

    // Receiver: stalls at random, or for one long counted stretch when the
    // sender asks for it.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                i_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Every write the block hands over is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            blit_board.check_write(o_frame_address, o_write_color);
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (i_valid && o_stall) input_stall_cycles++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_sprite_blit_engine_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int phase;
        blit_board          = new();
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        hold_request        = 1'b0;
        useful_items        = 0;
        input_stall_cycles  = 0;
        holds_done          = 0;
        idle_run            = 0;
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_stall             = 1'b0;
        i_command           = CMD_START;
        i_dest_x            = '0;
        i_dest_y            = '0;
        i_sprite_width      = '0;
        i_sprite_height     = '0;
        i_mirror_x          = 1'b0;
        i_anchor_bottom     = 1'b0;
        i_center_horizontal = 1'b0;
        i_center_vertical   = 1'b0;
        i_pixel_color       = '0;
        i_pixel_opaque      = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        drain_writes();

        // Three phases: first the receiver stalls often, then the sender
        // idles often, then both run flat out. Each phase opens with a long
        // hold-off and ends with the sender waiting for the output to empty.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            flood_with_hold();
            while (useful_items < 25 + (phase + 1) * PHASE_ITEMS) random_sprite();
            drain_writes();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_writes();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d items that drove the draw, %0d framebuffer writes checked.",
                 useful_items, blit_board.writes_checked);
        $display("Input was stalled for %0d cycles across %0d receiver hold-offs.",
                 input_stall_cycles, holds_done);
        if (blit_board.mismatches == 0 && blit_board.pending_writes.size() == 0) begin
            $display("tb_sprite_blit_engine_unit: done, clean");
        end else begin
            $display("tb_sprite_blit_engine_unit: done, errors");
        end
        $finish;
    end

endmodule
